// ===== sv/mf3_pkg.sv =====
// Shared types, register map and compare helpers for the 3x3 median filter.
package mf3_pkg;

  typedef logic [7:0] pix_t;
  typedef pix_t win_t [9];

  localparam int unsigned CFG_AW         = 3;
  localparam int unsigned LW_W           = 11;
  localparam logic        REG_LINE_WIDTH = 1'b0;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd256;
  localparam logic [1:0]  ROW_FULL       = 2'd2;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

// ===== sv/mf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mf3_median.sv =====
// Two-stage median-of-nine network: column sort, then median of the three partials.
module mf3_median (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  mf3_pkg::win_t win,
  output logic          out_valid,
  output mf3_pkg::pix_t out_median
);
  import mf3_pkg::*;

  logic b_v_r;
  pix_t lo_r [3];
  pix_t md_r [3];
  pix_t hi_r [3];
  logic c_v_r;
  pix_t a_r, m_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= in_valid;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= min3(win[j], win[3+j], win[6+j]);
        md_r[j] <= med3(win[j], win[3+j], win[6+j]);
        hi_r[j] <= max3(win[j], win[3+j], win[6+j]);
      end
      a_r <= max3(lo_r[0], lo_r[1], lo_r[2]);
      m_r <= med3(md_r[0], md_r[1], md_r[2]);
      z_r <= min3(hi_r[0], hi_r[1], hi_r[2]);
    end
  end

  assign out_valid  = c_v_r;
  assign out_median = med3(a_r, m_r, z_r);

endmodule

// ===== sv/median_filter_3x3.sv =====
// Top level of the 3x3 median filter over a raster-order grey pixel stream.
// A median is registered in the line RAM read stage, the window, both median stages and the output register.
// Throughput: one pixel per cycle while the skid stage is empty, set by the single read-modify-write of the line RAM.
// Reset clears counters, pipeline and output valids and sets line_width to 256;
// the line RAM is not cleared and needs no clearing pass.
module median_filter_3x3 #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,    // [7:0] pixel
  input  logic [0:0]                   in_tuser,    // [0] frame_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,   // [7:0] median
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mf3_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int EW = ($clog2(MAX_LINE_WIDTH + 1) > LW_W) ? $clog2(MAX_LINE_WIDTH + 1) : LW_W;

  logic [LW_W-1:0] line_width_r;
  logic [EW-1:0]   lw_ext, eff_w;

  logic [AW-1:0]   col_r, col_nxt;
  logic [1:0]      row_r, row_nxt;
  logic [AW-1:0]   col_eff;
  logic [1:0]      row_eff;
  logic [EW-1:0]   col_ext, c_ext;
  logic [AW-1:0]   c_addr;
  logic            prod;

  logic            en, acc;

  logic            s1_v_r, s1_prod_r;
  logic [AW-1:0]   s1_addr_r;
  pix_t            s1_px_r;
  logic            fwd_sel_r;
  logic [15:0]     fwd_data_r;
  logic [15:0]     ram_rdata, rd, wdata;
  logic            we;
  pix_t            top, mid;

  win_t            win_r;
  logic            s2_v_r;

  logic            med_v;
  pix_t            med;

  logic            out_v_r, sk_v_r;
  pix_t            out_d_r, sk_d_r;
  logic            pop, push;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LINE_WIDTH) ? {{(32-LW_W){1'b0}}, line_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_LINE_WIDTH) begin
      line_width_r <= cfg_pwdata[LW_W-1:0];
    end
  end

  assign lw_ext = EW'(line_width_r);

  always_comb begin
    if (lw_ext < EW'(3)) begin
      eff_w = EW'(3);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      eff_w = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
  end

  // Column and row tracking
  assign en  = !sk_v_r;
  assign in_tready = en;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    col_eff = in_tuser[0] ? '0 : col_r;
    row_eff = in_tuser[0] ? '0 : row_r;
    col_ext = EW'(col_eff);
    c_ext   = (col_ext >= eff_w) ? eff_w - EW'(1) : col_ext;
    c_addr  = c_ext[AW-1:0];
    prod    = (row_eff >= ROW_FULL) && (c_ext >= EW'(2));
    if (col_ext + EW'(1) >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_eff < ROW_FULL) ? row_eff + 2'd1 : row_eff;
    end else begin
      col_nxt = col_eff + AW'(1);
      row_nxt = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line RAM: [15:8] older row, [7:0] newer row
  assign we    = en && s1_v_r;
  assign rd    = fwd_sel_r ? fwd_data_r : ram_rdata;
  assign top   = rd[15:8];
  assign mid   = rd[7:0];
  assign wdata = {mid, s1_px_r};

  mf3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .re    (acc),
    .raddr (c_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
    end
  end

  // Forward the write that lands on the same edge as a read of the same column
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r  <= c_addr;
      s1_px_r    <= in_tdata;
      s1_prod_r  <= prod;
      fwd_sel_r  <= we && (s1_addr_r == c_addr);
      fwd_data_r <= wdata;
    end
  end

  // Window: row 0 oldest, column 2 newest
  always_ff @(posedge clk) begin
    if (we) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top;
      win_r[5] <= mid;
      win_r[8] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_prod_r;
    end
  end

  mf3_median u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s2_v_r),
    .win        (win_r),
    .out_valid  (med_v),
    .out_median (med)
  );

  // Output register with skid stage
  assign pop  = out_v_r && out_tready;
  assign push = en && med_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_v_r && !pop) begin
      if (push) begin
        sk_v_r <= 1'b1;
      end
    end else if (sk_v_r) begin
      out_v_r <= 1'b1;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !pop) begin
      if (push) begin
        sk_d_r <= med;
      end
    end else if (sk_v_r) begin
      out_d_r <= sk_d_r;
    end else if (push) begin
      out_d_r <= med;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ===== sim/tb_median_filter_3x3.sv =====
// Self-checking testbench for the 3x3 median filter: random pixel frames, line widths and flow.
module tb_median_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int MAX_LW = 1024;
  localparam int SETTLE = 8;
  localparam int RANDOM_ITEMS = 150;
  localparam int MIN_SEGS = 6;
  localparam logic [CFG_AW-1:0] ADDR_LINE_WIDTH = {REG_LINE_WIDTH, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE = 3'd4;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

  class median_sb_t;
    pix_t            line_mem [2*MAX_LW];
    pix_t            win [9];
    int unsigned     col;
    int unsigned     rows;
    logic [LW_W-1:0] line_width;
    pix_t            medians_due [$];
    int              errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col = 0;
      rows = 0;
      line_width = LINE_WIDTH_RST;
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == REG_LINE_WIDTH) line_width = value[LW_W-1:0];
    endfunction

    function int unsigned row_len();
      int unsigned w;
      w = line_width;
      if (w < 3) w = 3;
      if (w > MAX_LW) w = MAX_LW;
      return w;
    endfunction

    function pix_t window_median();
      int lt;
      int le;
      for (int i = 0; i < 9; i++) begin
        lt = 0;
        le = 0;
        for (int k = 0; k < 9; k++) begin
          if (win[k] < win[i]) lt++;
          if (win[k] <= win[i]) le++;
        end
        if (lt <= 4 && le >= 5) return win[i];
      end
      return '0;
    endfunction

    function void note_pixel(pix_t px, logic fs);
      int unsigned w;
      int unsigned c;
      pix_t top;
      pix_t mid;
      w = row_len();
      if (fs) begin
        col = 0;
        rows = 0;
      end
      c = (col >= w) ? w - 1 : col;
      top = line_mem[MAX_LW + c];
      mid = line_mem[c];
      line_mem[MAX_LW + c] = mid;
      line_mem[c] = px;
      for (int r = 0; r < 3; r++) begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (rows >= ROW_FULL && c >= 2) medians_due.push_back(window_median());
      if (col + 1 >= w) begin
        col = 0;
        if (rows < ROW_FULL) rows++;
      end else begin
        col++;
      end
    endfunction

    function void check_median(pix_t got);
      pix_t want;
      if (medians_due.size() == 0) begin
        $error("median: expected none, got %0d", got);
        errors++;
      end else begin
        want = medians_due.pop_front();
        if (got !== want) begin
          $error("median: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return medians_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  median_sb_t sb = new();
  flow_t flow = FLOW_FREE;
  int hold_req = 0;
  int hold_left = 0;
  int bad_reads = 0;

  median_filter_3x3 #(.MAX_LINE_WIDTH(MAX_LW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls per flow phase, long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (flow == FLOW_SNK_STALL) begin
      out_tready <= ($urandom_range(99) >= 66);
    end else if (flow == FLOW_BOTH) begin
      out_tready <= ($urandom_range(99) >= 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_median(out_tdata);
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata, in_tuser[0]);
    end
  end

  function automatic bit src_idles();
    if (flow == FLOW_SRC_IDLE) return ($urandom_range(99) < 66);
    if (flow == FLOW_BOTH) return ($urandom_range(99) < 18);
    return 1'b0;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return pix_t'($urandom_range(100, 103));
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input pix_t px, input logic fs);
    if (src_idles()) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (src_idles());
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(addr >> 2, data);
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_width_reg();
    logic [31:0] rd;
    logic [31:0] want;
    apb_read(ADDR_LINE_WIDTH, rd);
    want = {{(32-LW_W){1'b0}}, sb.line_width};
    if (rd !== want) begin
      $error("line_width: expected %0d, got %0d", want, rd);
      bad_reads++;
    end
  endtask

  task automatic set_width(input int unsigned w);
    logic [31:0] data;
    data = $urandom();
    data[LW_W-1:0] = w[LW_W-1:0];
    apb_write(ADDR_LINE_WIDTH, data);
    check_width_reg();
  endtask

  function automatic int unsigned pick_width();
    case ($urandom_range(15))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(25, 64);
      default: return $urandom_range(3, 16);
    endcase
  endfunction

  initial begin
    int rand_items;
    int seg;
    int nframes;
    int nrows;
    int len;
    int unsigned eff;
    int n;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset value, spare address, clamp below three, extremes, frame restarts
    check_width_reg();
    apb_write(ADDR_SPARE, $urandom());
    check_width_reg();
    set_width(0);
    for (int i = 0; i < 12; i++)
      send_pixel((i < 9) ? ((i % 2) ? 8'hFF : 8'h00) : 8'hFF, i == 0);
    send_pixel(8'h80, 1'b1);
    send_pixel(8'h7F, 1'b0);
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel(), i == 0);
    drain();

    // widest row, then shrink below the current column mid-row
    set_width(1025);
    for (int i = 0; i < MAX_LW + 5; i++) send_pixel(rand_pixel(), i == 0);
    drain();
    set_width(4);
    for (int i = 0; i < 16; i++) send_pixel(rand_pixel(), 1'b0);
    drain();
    set_width(2047);

    rand_items = 0;
    seg = 0;
    while (seg < MIN_SEGS || rand_items < RANDOM_ITEMS) begin
      drain();
      set_width((seg == 2) ? 8 : pick_width());
      eff = sb.row_len();
      flow = flow_t'(seg % 4);
      nframes = $urandom_range(1, 2);
      if (seg == 2) hold_req = 600;
      for (int f = 0; f < nframes; f++) begin
        nrows = (seg == 2) ? 6 : $urandom_range(3, 4);
        len = nrows * eff + $urandom_range(0, eff - 1);
        for (int k = 0; k < len; k++) begin
          if (seg == 5 && f == 0 && k == len / 2) drain();
          send_pixel(rand_pixel(), (k == 0) || ($urandom_range(99) < 2));
        end
        rand_items += len;
      end
      if (eff > 3 && $urandom_range(2) == 0) begin
        drain();
        set_width($urandom_range(3, eff - 1));
        len = 3 * sb.row_len() + $urandom_range(0, 20);
        for (int k = 0; k < len; k++) send_pixel(rand_pixel(), 1'b0);
        rand_items += len;
      end
      seg++;
    end

    in_tvalid <= 1'b0;
    for (n = 0; n < 200000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) $error("median: %0d results never arrived", sb.pending());
    if (sb.errors == 0 && bad_reads == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mf3_pkg.sv
sv/mf3_ram.sv
sv/mf3_median.sv
sv/median_filter_3x3.sv
sim/tb_median_filter_3x3.sv
